// File: hdl/polynomial_derivative_quotient_defines.svh
// Assertion macros for the polynomial derivative quotient RTL
`ifndef POLYNOMIAL_DERIVATIVE_QUOTIENT_DEFINES_SVH
`define POLYNOMIAL_DERIVATIVE_QUOTIENT_DEFINES_SVH
`ifndef SYNTHESIS
`define PDQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define PDQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define PDQ_ASSERT(lbl, prop, msg)
`define PDQ_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

// File: hdl/pdq_pkg.sv
// Shared constants and types for the polynomial derivative quotient block
package pdq_pkg;
  localparam int MAX_LEN_DEF = 16;
  localparam int MAX_LEN_HI  = 16;
  localparam int COEF_W      = 16;
  localparam int ACC_W       = 41;
  localparam int WGT_W       = $clog2(MAX_LEN_HI);
  localparam int YW_W        = COEF_W + WGT_W + 1;
  localparam int PROD_W      = COEF_W + YW_W;

  // one multiply-accumulate term issued by the sequencer
  typedef struct packed {
    logic             vld;
    logic             clr;
    logic             x_one;
    logic             x_den;
    logic             y_den;
    logic             neg;
    logic [WGT_W-1:0] w;
  } mac_ctl_t;
endpackage

// File: hdl/pdq_mem.sv
// Coefficient store: one write port, two registered read ports
module pdq_mem #(
  parameter int DEPTH = pdq_pkg::MAX_LEN_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                              clk,
  input  logic                              we,
  input  logic [AW-1:0]                     waddr,
  input  logic signed [pdq_pkg::COEF_W-1:0] wdata,
  input  logic [AW-1:0]                     raddr0,
  input  logic [AW-1:0]                     raddr1,
  output logic signed [pdq_pkg::COEF_W-1:0] rdata0_r,
  output logic signed [pdq_pkg::COEF_W-1:0] rdata1_r
);
  import pdq_pkg::*;

  logic signed [COEF_W-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata0_r <= mem_r[raddr0];
    rdata1_r <= mem_r[raddr1];
  end
endmodule

// File: hdl/pdq_mac.sv
// Multiply-accumulate pipe: operand select, weight multiply, product, accumulate
module pdq_mac (
  input  logic                              clk,
  input  logic                              rst_n,
  input  pdq_pkg::mac_ctl_t                 ctl,
  input  logic signed [pdq_pkg::COEF_W-1:0] num_rd0,
  input  logic signed [pdq_pkg::COEF_W-1:0] num_rd1,
  input  logic signed [pdq_pkg::COEF_W-1:0] den_rd0,
  input  logic signed [pdq_pkg::COEF_W-1:0] den_rd1,
  output logic                              busy,
  output logic signed [pdq_pkg::ACC_W-1:0]  acc_r
);
  import pdq_pkg::*;

  mac_ctl_t                 c1_r;
  logic                     v2_r, v3_r, neg2_r, neg3_r;
  logic signed [COEF_W-1:0] y_sel, xs_nxt, xs_r;
  logic signed [YW_W-1:0]   yw_nxt, yw_r;
  logic signed [PROD_W-1:0] prod_nxt, prod_r;

  always_comb begin
    y_sel = c1_r.y_den ? den_rd1 : num_rd1;
    if (!c1_r.vld) begin
      xs_nxt = '0;
      yw_nxt = '0;
    end else begin
      xs_nxt = c1_r.x_one ? COEF_W'(1) : (c1_r.x_den ? den_rd0 : num_rd0);
      yw_nxt = YW_W'(y_sel) * $signed(YW_W'(c1_r.w));
    end
    prod_nxt = PROD_W'(xs_r) * PROD_W'(yw_r);
  end

  assign busy = c1_r.vld | v2_r | v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r <= '0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      c1_r <= ctl;
      v2_r <= c1_r.vld;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    xs_r   <= xs_nxt;
    yw_r   <= yw_nxt;
    neg2_r <= c1_r.neg;
    prod_r <= prod_nxt;
    neg3_r <= neg2_r;
    if (ctl.clr) begin
      acc_r <= '0;
    end else if (v3_r) begin
      acc_r <= neg3_r ? acc_r - ACC_W'(prod_r) : acc_r + ACC_W'(prod_r);
    end
  end
endmodule

// File: hdl/pdq_seq.sv
// Load control, term sequencing, leading-zero trim and output register
`include "polynomial_derivative_quotient_defines.svh"
module pdq_seq #(
  parameter int MAX_LEN = pdq_pkg::MAX_LEN_DEF,
  localparam int AW = $clog2(MAX_LEN)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_target,
  input  logic                              in_carries_coef,
  input  logic                              in_end_of_load,
  input  logic                              cfg_quotient_mode,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [pdq_pkg::ACC_W-1:0]  out_coef_out,
  output logic                              out_which_poly,
  output logic                              out_empty_poly,
  output logic                              out_too_long,
  output logic                              out_last_result,
  output logic                              num_we,
  output logic                              den_we,
  output logic [AW-1:0]                     num_waddr,
  output logic [AW-1:0]                     den_waddr,
  output logic [AW-1:0]                     x_raddr,
  output logic [AW-1:0]                     y_raddr,
  output pdq_pkg::mac_ctl_t                 mac_ctl,
  input  logic                              mac_busy,
  input  logic signed [pdq_pkg::ACC_W-1:0]  acc
);
  import pdq_pkg::*;

  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int KW = $clog2(2 * MAX_LEN);
  localparam int IW = KW + 2;

  typedef enum logic [4:0] {
    ST_LOAD  = 5'b00001,
    ST_START = 5'b00010,
    ST_ISSUE = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  typedef enum logic [2:0] {
    PH_SINGLE = 3'b001,
    PH_NUM    = 3'b010,
    PH_DEN    = 3'b100
  } phase_t;

  state_t  state_r, state_nxt;
  phase_t  phase_r, phase_nxt;
  logic [LW-1:0] num_len_r, num_len_nxt, den_len_r, den_len_nxt, j_r, j_nxt;
  logic          ovf_r, ovf_nxt, sub_r, sub_nxt, empty_r, empty_nxt, trim_r, trim_nxt;
  logic [KW-1:0] k_r, k_nxt, len_r, len_nxt, off1_r, off1_nxt, off2_r, off2_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic signed [ACC_W-1:0] out_coef_r;
  logic          out_which_r, out_empty_r, out_too_long_r, out_last_r;

  logic          in_fire, num_full, den_full;
  logic [KW-1:0] nb_k, na_k, nbp_k, nap_k, l1_k, l2_k, lmax_k, aa_k, off;
  logic          deriv, x_one, x_den, y_den, neg_t, term_ok, last_j;
  logic [LW-1:0] cnt, ylen;
  logic signed [IW-1:0] m_s, ylim_s, w_s;
  logic          lastk, skip, out_free, out_load, clr;

  assign in_stall  = (state_r != ST_LOAD);
  assign in_fire   = in_valid && !in_stall;
  assign num_full  = (num_len_r == LW'(MAX_LEN));
  assign den_full  = (den_len_r == LW'(MAX_LEN));
  assign num_we    = in_fire && in_carries_coef && !in_target && !num_full;
  assign den_we    = in_fire && in_carries_coef && in_target && !den_full;
  assign num_waddr = num_len_r[AW-1:0];
  assign den_waddr = den_len_r[AW-1:0];

  // result lengths for the setup cycle
  always_comb begin
    nb_k   = KW'(num_len_r);
    na_k   = KW'(den_len_r);
    nbp_k  = (num_len_r <= LW'(1)) ? KW'(1) : nb_k - KW'(1);
    nap_k  = (den_len_r <= LW'(1)) ? KW'(1) : na_k - KW'(1);
    l1_k   = (den_len_r == '0) ? '0 : na_k + nbp_k - KW'(1);
    l2_k   = (num_len_r == '0) ? '0 : nb_k + nap_k - KW'(1);
    lmax_k = (l1_k > l2_k) ? l1_k : l2_k;
    aa_k   = (den_len_r == '0) ? '0 : na_k + na_k - KW'(1);
  end

  // term selection: x from port 0 at j, y from port 1 at m = k - off - j
  always_comb begin
    deriv = 1'b1;
    x_one = 1'b0;
    x_den = 1'b0;
    y_den = 1'b0;
    neg_t = 1'b0;
    cnt   = LW'(1);
    unique case (phase_r)
      PH_SINGLE: begin
        x_one = 1'b1;
      end
      PH_NUM: begin
        if (!sub_r) begin
          x_den = 1'b1;
          cnt   = den_len_r;
        end else begin
          y_den = 1'b1;
          neg_t = 1'b1;
          cnt   = num_len_r;
        end
      end
      PH_DEN: begin
        deriv = 1'b0;
        x_den = 1'b1;
        y_den = 1'b1;
        cnt   = den_len_r;
      end
      default: begin
        x_one = 1'b1;
      end
    endcase
    ylen    = y_den ? den_len_r : num_len_r;
    off     = sub_r ? off2_r : off1_r;
    m_s     = $signed(IW'(k_r)) - $signed(IW'(off)) - $signed(IW'(j_r));
    ylim_s  = deriv ? $signed(IW'(ylen)) - $signed(IW'(1)) : $signed(IW'(ylen));
    w_s     = $signed(IW'(ylen)) - m_s - $signed(IW'(1));
    term_ok = (j_r < cnt) && (m_s >= $signed(IW'(0))) && (m_s < ylim_s);
    last_j  = ((j_r + LW'(1)) >= cnt);

    mac_ctl.vld   = (state_r == ST_ISSUE) && term_ok;
    mac_ctl.clr   = clr;
    mac_ctl.x_one = x_one;
    mac_ctl.x_den = x_den;
    mac_ctl.y_den = y_den;
    mac_ctl.neg   = neg_t;
    mac_ctl.w     = deriv ? w_s[WGT_W-1:0] : WGT_W'(1);
  end

  assign x_raddr  = j_r[AW-1:0];
  assign y_raddr  = m_s[AW-1:0];
  assign lastk    = (k_r == len_r - KW'(1));
  assign skip     = trim_r && (acc == '0) && !lastk;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt   = state_r;
    phase_nxt   = phase_r;
    num_len_nxt = num_len_r;
    den_len_nxt = den_len_r;
    ovf_nxt     = ovf_r;
    k_nxt       = k_r;
    j_nxt       = j_r;
    sub_nxt     = sub_r;
    len_nxt     = len_r;
    off1_nxt    = off1_r;
    off2_nxt    = off2_r;
    empty_nxt   = empty_r;
    trim_nxt    = trim_r;
    clr         = 1'b0;
    out_load    = 1'b0;

    if (num_we) num_len_nxt = num_len_r + LW'(1);
    if (den_we) den_len_nxt = den_len_r + LW'(1);
    if (in_fire && in_carries_coef && (in_target ? den_full : num_full)) ovf_nxt = 1'b1;

    unique case (state_r)
      ST_LOAD: begin
        if (in_fire && in_end_of_load) begin
          phase_nxt = cfg_quotient_mode ? PH_NUM : PH_SINGLE;
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        k_nxt   = '0;
        j_nxt   = '0;
        sub_nxt = 1'b0;
        clr     = 1'b1;
        unique case (phase_r)
          PH_NUM: begin
            len_nxt   = (lmax_k == '0) ? KW'(1) : lmax_k;
            empty_nxt = (lmax_k == '0);
            off1_nxt  = lmax_k - l1_k;
            off2_nxt  = lmax_k - l2_k;
            trim_nxt  = 1'b1;
          end
          PH_DEN: begin
            len_nxt   = (den_len_r == '0) ? KW'(1) : aa_k;
            empty_nxt = (den_len_r == '0);
            off1_nxt  = '0;
            off2_nxt  = '0;
            trim_nxt  = 1'b1;
          end
          default: begin
            len_nxt   = (num_len_r <= LW'(1)) ? KW'(1) : nb_k - KW'(1);
            empty_nxt = (num_len_r == '0);
            off1_nxt  = '0;
            off2_nxt  = '0;
            trim_nxt  = 1'b0;
          end
        endcase
        state_nxt = ST_ISSUE;
      end
      ST_ISSUE: begin
        j_nxt = j_r + LW'(1);
        if (last_j) begin
          if ((phase_r == PH_NUM) && !sub_r) begin
            sub_nxt = 1'b1;
            j_nxt   = '0;
          end else begin
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (!mac_busy) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (skip || out_free) begin
          clr      = 1'b1;
          out_load = !skip;
          if (!skip) trim_nxt = 1'b0;
          if (!lastk) begin
            k_nxt     = k_r + KW'(1);
            j_nxt     = '0;
            sub_nxt   = 1'b0;
            state_nxt = ST_ISSUE;
          end else if (phase_r == PH_NUM) begin
            phase_nxt = PH_DEN;
            state_nxt = ST_START;
          end else begin
            num_len_nxt = '0;
            den_len_nxt = '0;
            ovf_nxt     = 1'b0;
            state_nxt   = ST_LOAD;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      phase_r     <= PH_SINGLE;
      num_len_r   <= '0;
      den_len_r   <= '0;
      ovf_r       <= 1'b0;
      k_r         <= '0;
      j_r         <= '0;
      sub_r       <= 1'b0;
      len_r       <= '0;
      off1_r      <= '0;
      off2_r      <= '0;
      empty_r     <= 1'b0;
      trim_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      num_len_r   <= num_len_nxt;
      den_len_r   <= den_len_nxt;
      ovf_r       <= ovf_nxt;
      k_r         <= k_nxt;
      j_r         <= j_nxt;
      sub_r       <= sub_nxt;
      len_r       <= len_nxt;
      off1_r      <= off1_nxt;
      off2_r      <= off2_nxt;
      empty_r     <= empty_nxt;
      trim_r      <= trim_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_coef_r     <= acc;
      out_which_r    <= (phase_r == PH_DEN);
      out_empty_r    <= empty_r;
      out_too_long_r <= ovf_r;
      out_last_r     <= lastk && (phase_r != PH_NUM);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_coef_out    = out_coef_r;
  assign out_which_poly  = out_which_r;
  assign out_empty_poly  = out_empty_r;
  assign out_too_long    = out_too_long_r;
  assign out_last_result = out_last_r;

  `PDQ_ASSERT_IMP(a_out_from_emit, $rose(out_valid_r), $past(state_r == ST_EMIT), "result not from emit")
  `PDQ_ASSERT_IMP(a_emit_pipe_empty, state_r == ST_EMIT, !mac_busy, "emit with terms in flight")
  `PDQ_ASSERT(a_len_bound, (num_len_r <= LW'(MAX_LEN)) && (den_len_r <= LW'(MAX_LEN)), "length overrun")
  `PDQ_ASSERT_IMP(a_store_quiet, state_r != ST_LOAD, !num_we && !den_we, "store written during compute")
endmodule

// File: hdl/polynomial_derivative_quotient.sv
// Top level: derivative of a polynomial or of a quotient of two polynomials
//  chan | handshake             | payload
//  in   | in_valid / in_stall   | in_coef_in, in_target, in_carries_coef, in_end_of_load
//  out  | out_valid / out_stall | out_coef_out, out_which_poly, out_empty_poly,
//       |                       | out_too_long, out_last_result
//  cfg  | cfg_valid / cfg_ready | cfg_quotient_mode
// An end-of-load transaction holds in_stall high until the last result is registered:
// a setup step per polynomial, then per coefficient an issue step for each term, a drain
// until the multiply-accumulate pipe is empty, and an emit; terms = 1 for a derivative,
// max(na,1) + max(nb,1) for the quotient numerator, max(na,1) for a*a.
// Out stalls hold the sequencer only at coefficient boundaries.
// Synchronous reset clears control, lengths and mode; coefficient stores are not cleared.
module polynomial_derivative_quotient #(
  parameter int MAX_LEN = pdq_pkg::MAX_LEN_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [pdq_pkg::COEF_W-1:0] in_coef_in,
  input  logic                              in_target,
  input  logic                              in_carries_coef,
  input  logic                              in_end_of_load,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [pdq_pkg::ACC_W-1:0]  out_coef_out,
  output logic                              out_which_poly,
  output logic                              out_empty_poly,
  output logic                              out_too_long,
  output logic                              out_last_result,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_quotient_mode
);
  import pdq_pkg::*;

  localparam int AW = $clog2(MAX_LEN);

  logic                     quotient_mode_r;
  logic                     num_we, den_we, mac_busy;
  logic [AW-1:0]            num_waddr, den_waddr, x_raddr, y_raddr;
  logic signed [COEF_W-1:0] num_rd0, num_rd1, den_rd0, den_rd1;
  mac_ctl_t                 mac_ctl;
  logic signed [ACC_W-1:0]  acc;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quotient_mode_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      quotient_mode_r <= cfg_quotient_mode;
    end
  end

  pdq_mem #(.DEPTH(MAX_LEN)) u_num_mem (
    .clk      (clk),
    .we       (num_we),
    .waddr    (num_waddr),
    .wdata    (in_coef_in),
    .raddr0   (x_raddr),
    .raddr1   (y_raddr),
    .rdata0_r (num_rd0),
    .rdata1_r (num_rd1)
  );

  pdq_mem #(.DEPTH(MAX_LEN)) u_den_mem (
    .clk      (clk),
    .we       (den_we),
    .waddr    (den_waddr),
    .wdata    (in_coef_in),
    .raddr0   (x_raddr),
    .raddr1   (y_raddr),
    .rdata0_r (den_rd0),
    .rdata1_r (den_rd1)
  );

  pdq_mac u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mac_ctl),
    .num_rd0 (num_rd0),
    .num_rd1 (num_rd1),
    .den_rd0 (den_rd0),
    .den_rd1 (den_rd1),
    .busy    (mac_busy),
    .acc_r   (acc)
  );

  pdq_seq #(.MAX_LEN(MAX_LEN)) u_seq (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_target         (in_target),
    .in_carries_coef   (in_carries_coef),
    .in_end_of_load    (in_end_of_load),
    .cfg_quotient_mode (quotient_mode_r),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_coef_out      (out_coef_out),
    .out_which_poly    (out_which_poly),
    .out_empty_poly    (out_empty_poly),
    .out_too_long      (out_too_long),
    .out_last_result   (out_last_result),
    .num_we            (num_we),
    .den_we            (den_we),
    .num_waddr         (num_waddr),
    .den_waddr         (den_waddr),
    .x_raddr           (x_raddr),
    .y_raddr           (y_raddr),
    .mac_ctl           (mac_ctl),
    .mac_busy          (mac_busy),
    .acc               (acc)
  );
endmodule

// File: sim/pdq_tb_pkg.sv
// Codes and the result record shared by the polynomial derivative quotient testbench
package pdq_tb_pkg;
  localparam logic TARGET_NUM    = 1'b0;
  localparam logic TARGET_DEN    = 1'b1;
  localparam logic MODE_SINGLE   = 1'b0;
  localparam logic MODE_QUOTIENT = 1'b1;
  localparam logic POLY_NUM      = 1'b0;
  localparam logic POLY_DEN      = 1'b1;

  typedef struct packed {
    logic signed [pdq_pkg::ACC_W-1:0] coef;
    logic                             which;
    logic                             is_empty;
    logic                             too_long;
    logic                             is_last;
  } pdq_result_t;
endpackage

// File: sim/polynomial_derivative_quotient_checker.sv
// Checker: mirrors the coefficient stores, predicts each result burst and compares it
module polynomial_derivative_quotient_checker #(
  parameter int MAX_LEN = pdq_pkg::MAX_LEN_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  input  logic                                     in_stall,
  input  logic signed [pdq_pkg::COEF_W-1:0]        in_coef_in,
  input  logic                                     in_target,
  input  logic                                     in_carries_coef,
  input  logic                                     in_end_of_load,
  input  logic                                     out_valid,
  input  logic                                     out_stall,
  input  logic signed [pdq_pkg::ACC_W-1:0]         out_coef_out,
  input  logic                                     out_which_poly,
  input  logic                                     out_empty_poly,
  input  logic                                     out_too_long,
  input  logic                                     out_last_result,
  input  logic                                     cfg_valid,
  input  logic                                     cfg_ready,
  input  logic                                     cfg_quotient_mode,
  output int                                       mismatches,
  output int                                       pending,
  output int                                       results_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import pdq_pkg::*;
  import pdq_tb_pkg::*;

  localparam logic PLAIN = 1'b0;
  localparam logic SLOPE = 1'b1;

  logic signed [COEF_W-1:0] num_coefs [MAX_LEN];
  logic signed [COEF_W-1:0] den_coefs [MAX_LEN];
  int                       num_len;
  int                       den_len;
  logic                     dropped;
  logic                     quot_mode;
  longint                   burst_buf [2*MAX_LEN];
  pdq_result_t              due_coefs [$];

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    if (mismatches <= 20) begin
      $display("%0t ns: mismatch on %s: got %0d, want %0d", $time, what, got, want);
    end
  endtask

  function automatic longint stored(input logic den, input int i);
    return den ? longint'(den_coefs[i]) : longint'(num_coefs[i]);
  endfunction

  function automatic int stored_len(input logic den);
    return den ? den_len : num_len;
  endfunction

  function automatic int slope_len(input int n);
    return (n <= 1) ? 1 : n - 1;
  endfunction

  // a store as loaded, or its derivative
  function automatic int operand_len(input logic den, input logic form);
    return (form == SLOPE) ? slope_len(stored_len(den)) : stored_len(den);
  endfunction

  function automatic longint operand_at(input logic den, input logic form, input int i);
    int n;
    n = stored_len(den);
    if (form == PLAIN) return stored(den, i);
    if (n <= 1) return 0;
    return stored(den, i) * (n - 1 - i);
  endfunction

  function automatic int product_len(input logic xd, input logic xf, input logic yd,
                                     input logic yf);
    int nx, ny;
    nx = operand_len(xd, xf);
    ny = operand_len(yd, yf);
    return (nx == 0 || ny == 0) ? 0 : nx + ny - 1;
  endfunction

  function automatic longint product_at(input logic xd, input logic xf, input logic yd,
                                        input logic yf, input int k);
    longint acc;
    int     nx, ny, i;
    acc = 0;
    nx = operand_len(xd, xf);
    ny = operand_len(yd, yf);
    for (i = 0; i < nx; i++) begin
      if (k - i >= 0 && k - i < ny) acc += operand_at(xd, xf, i) * operand_at(yd, yf, k - i);
    end
    return acc;
  endfunction

  task automatic push_expect(input longint value, input logic which, input logic is_empty,
                             input logic is_last);
    pdq_result_t r;
    r.coef     = value[ACC_W-1:0];
    r.which    = which;
    r.is_empty = is_empty;
    r.too_long = dropped;
    r.is_last  = is_last;
    due_coefs.push_back(r);
  endtask

  task automatic push_trimmed(input int span, input logic which, input logic closes_burst);
    int lo, i;
    if (span == 0) begin
      push_expect(0, which, 1'b1, closes_burst);
    end else begin
      lo = 0;
      while (lo + 1 < span && burst_buf[lo] == 0) lo++;
      for (i = lo; i < span; i++) begin
        push_expect(burst_buf[i], which, 1'b0, closes_burst && i == span - 1);
      end
    end
  endtask

  task automatic predict_derivative();
    int     l1, l2, span, i;
    longint lead, tail;
    if (quot_mode == MODE_SINGLE) begin
      span = slope_len(num_len);
      for (i = 0; i < span; i++) begin
        push_expect(operand_at(TARGET_NUM, SLOPE, i), POLY_NUM, num_len == 0, i == span - 1);
      end
    end else begin
      // a*b' - b*a', right aligned, then a*a
      l1 = product_len(TARGET_DEN, PLAIN, TARGET_NUM, SLOPE);
      l2 = product_len(TARGET_NUM, PLAIN, TARGET_DEN, SLOPE);
      span = (l1 > l2) ? l1 : l2;
      for (i = 0; i < span; i++) begin
        lead = (i + l1 >= span) ? product_at(TARGET_DEN, PLAIN, TARGET_NUM, SLOPE, i + l1 - span)
                                : 0;
        tail = (i + l2 >= span) ? product_at(TARGET_NUM, PLAIN, TARGET_DEN, SLOPE, i + l2 - span)
                                : 0;
        burst_buf[i] = lead - tail;
      end
      push_trimmed(span, POLY_NUM, 1'b0);
      span = product_len(TARGET_DEN, PLAIN, TARGET_DEN, PLAIN);
      for (i = 0; i < span; i++) begin
        burst_buf[i] = product_at(TARGET_DEN, PLAIN, TARGET_DEN, PLAIN, i);
      end
      push_trimmed(span, POLY_DEN, 1'b1);
    end
  endtask

  task automatic absorb_item();
    if (in_carries_coef) begin
      if (in_target == TARGET_DEN) begin
        if (den_len < MAX_LEN) begin
          den_coefs[den_len] = in_coef_in;
          den_len++;
        end else begin
          dropped = 1'b1;
        end
      end else begin
        if (num_len < MAX_LEN) begin
          num_coefs[num_len] = in_coef_in;
          num_len++;
        end else begin
          dropped = 1'b1;
        end
      end
    end
    if (in_end_of_load) begin
      predict_derivative();
      num_len = 0;
      den_len = 0;
      dropped = 1'b0;
    end
  endtask

  task automatic check_result();
    pdq_result_t want;
    results_seen++;
    if (due_coefs.size() == 0) begin
      report_mismatch("coef_out with nothing expected", longint'(out_coef_out), 0);
    end else begin
      want = due_coefs.pop_front();
      if (out_coef_out !== want.coef)
        report_mismatch("coef_out", longint'(out_coef_out), longint'(want.coef));
      if (out_which_poly !== want.which)
        report_mismatch("which_poly", longint'(out_which_poly), longint'(want.which));
      if (out_empty_poly !== want.is_empty)
        report_mismatch("empty_poly", longint'(out_empty_poly), longint'(want.is_empty));
      if (out_too_long !== want.too_long)
        report_mismatch("too_long", longint'(out_too_long), longint'(want.too_long));
      if (out_last_result !== want.is_last)
        report_mismatch("last_result", longint'(out_last_result), longint'(want.is_last));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      num_len   = 0;
      den_len   = 0;
      dropped   = 1'b0;
      quot_mode = MODE_SINGLE;
    end else begin
      if (out_valid && !out_stall) check_result();
      if (cfg_valid && cfg_ready) quot_mode = cfg_quotient_mode;
      if (in_valid && !in_stall) absorb_item();
    end
    pending = due_coefs.size();
  end
endmodule

// File: sim/polynomial_derivative_quotient_test.sv
// Testbench top: drives loads, mode writes and output stalls, and gives the verdict
module polynomial_derivative_quotient_test;
  timeunit 1ns;
  timeprecision 1ps;
  import pdq_pkg::*;
  import pdq_tb_pkg::*;

  localparam int STORE_DEPTH    = MAX_LEN_DEF;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 8;
  localparam int DRAIN_CYCLES   = 100;
  localparam int WATCHDOG_LIMIT = 20000;

  logic                     clk               = 1'b0;
  logic                     rst_n             = 1'b0;
  logic                     in_valid          = 1'b0;
  logic                     in_stall;
  logic signed [COEF_W-1:0] in_coef_in        = '0;
  logic                     in_target         = TARGET_NUM;
  logic                     in_carries_coef   = 1'b0;
  logic                     in_end_of_load    = 1'b0;
  logic                     out_valid;
  logic                     out_stall         = 1'b0;
  logic signed [ACC_W-1:0]  out_coef_out;
  logic                     out_which_poly;
  logic                     out_empty_poly;
  logic                     out_too_long;
  logic                     out_last_result;
  logic                     cfg_valid         = 1'b0;
  logic                     cfg_ready;
  logic                     cfg_quotient_mode = MODE_SINGLE;

  int   mismatches;
  int   pending;
  int   results_seen;
  int   items_sent   = 0;
  int   send_idle    = 0;
  int   recv_idle    = 0;
  logic hold_go      = 1'b0;
  logic hold_seen    = 1'b0;
  int   hold_left    = 0;
  int   quiet_cycles = 0;

  always #5 clk = ~clk;

  polynomial_derivative_quotient #(.MAX_LEN(STORE_DEPTH)) u_top (.*);

  polynomial_derivative_quotient_checker #(.MAX_LEN(STORE_DEPTH)) u_checker (.*);

  // receiver: random stalls plus one long hold-off
  always @(negedge clk) begin
    if (hold_seen != hold_go) begin
      hold_seen = hold_go;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall = 1'b1;
    end else begin
      out_stall = ($urandom_range(99) < recv_idle);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", quiet_cycles);
      $display("polynomial_derivative_quotient_test: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(input logic signed [COEF_W-1:0] coef, input logic target,
                           input logic carries, input logic eol);
    while ($urandom_range(99) < send_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid        = 1'b1;
    in_coef_in      = coef;
    in_target       = target;
    in_carries_coef = carries;
    in_end_of_load  = eol;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_mode(input logic mode);
    cfg_valid         = 1'b1;
    cfg_quotient_mode = mode;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic signed [COEF_W-1:0] pick_coef();
    case ($urandom_range(9))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return '0;
      3, 4, 5: return $signed(COEF_W'($urandom_range(20) - 10));
      default: return $signed(COEF_W'($urandom));
    endcase
  endfunction

  function automatic int pick_len();
    case ($urandom_range(19))
      0, 1:    return 0;
      2:       return 1;
      3:       return STORE_DEPTH;
      4:       return STORE_DEPTH + 1;
      default: return $urandom_range(2, 6);
    endcase
  endfunction

  // one load: coefficients for both stores interleaved, some ignored items, one end marker
  task automatic send_load(input int n_num, input int n_den, input logic scaled);
    logic signed [COEF_W-1:0] num_vals [STORE_DEPTH+2];
    logic signed [COEF_W-1:0] den_vals [STORE_DEPTH+2];
    int   ni, di, k, i, total;
    logic to_den, closing;
    ni      = 0;
    di      = 0;
    closing = 1'b0;
    k       = int'($urandom_range(6)) - 3;
    for (i = 0; i < STORE_DEPTH + 2; i++) begin
      den_vals[i] = scaled ? $signed(COEF_W'($urandom_range(20000) - 10000)) : pick_coef();
      num_vals[i] = scaled ? $signed(COEF_W'(den_vals[i] * k)) : pick_coef();
    end
    total = n_num + n_den;
    while (ni + di < total) begin
      if ($urandom_range(9) == 0)
        send_item($signed(COEF_W'($urandom)), 1'($urandom_range(1)), 1'b0, 1'b0);
      if (ni == n_num) to_den = 1'b1;
      else if (di == n_den) to_den = 1'b0;
      else to_den = 1'($urandom_range(1));
      closing = (ni + di == total - 1) && $urandom_range(1);
      if (to_den) begin
        send_item(den_vals[di], TARGET_DEN, 1'b1, closing);
        di++;
      end else begin
        send_item(num_vals[ni], TARGET_NUM, 1'b1, closing);
        ni++;
      end
    end
    if (!closing) send_item($signed(COEF_W'($urandom)), 1'($urandom_range(1)), 1'b0, 1'b1);
  endtask

  task automatic random_load(input logic mode);
    int nn, nd;
    if (mode == MODE_QUOTIENT && $urandom_range(5) == 0) begin
      nd = pick_len();
      send_load(nd, nd, 1'b1);
    end else begin
      nn = pick_len();
      nd = (mode == MODE_QUOTIENT || $urandom_range(3) == 0) ? pick_len() : 0;
      send_load(nn, nd, 1'b0);
    end
  endtask

  task automatic run_segment(input logic mode, input int count);
    int stop;
    wait_idle();
    write_mode(mode);
    stop = items_sent + count;
    while (items_sent < stop) random_load(mode);
  endtask

  initial begin
    int i;
    repeat (11) @(negedge clk);
    rst_n     = 1'b1;
    send_idle = 13;
    recv_idle = 70;

    write_mode(MODE_SINGLE);
    send_item(16'sh7fff, TARGET_NUM, 1'b0, 1'b1);
    send_item(16'sd7, TARGET_NUM, 1'b1, 1'b1);
    send_item(-16'sd5, TARGET_DEN, 1'b1, 1'b0);
    send_item(16'sh7fff, TARGET_NUM, 1'b1, 1'b0);
    send_item(16'sh8000, TARGET_NUM, 1'b1, 1'b1);
    // full store, then one coefficient too many on the end marker
    for (i = 0; i <= STORE_DEPTH; i++) begin
      send_item(i[0] ? 16'sh8000 : 16'sh7fff, TARGET_NUM, 1'b1, i == STORE_DEPTH);
    end
    wait_idle();
    write_mode(MODE_QUOTIENT);
    send_item('0, TARGET_DEN, 1'b0, 1'b1);
    send_item(16'sd1, TARGET_DEN, 1'b1, 1'b0);
    send_item(16'sd3, TARGET_NUM, 1'b1, 1'b0);
    send_item(-16'sd2, TARGET_DEN, 1'b1, 1'b1);

    run_segment(MODE_SINGLE, 20);
    run_segment(MODE_QUOTIENT, 20);
    wait_idle();
    send_idle = 70;
    recv_idle = 13;
    run_segment(MODE_SINGLE, 20);
    run_segment(MODE_QUOTIENT, 20);
    wait_idle();
    send_idle = 0;
    recv_idle = 0;
    run_segment(MODE_SINGLE, 20);
    run_segment(MODE_QUOTIENT, 20);

    // back pressure: hold the output while a long burst runs and more items wait
    send_load(STORE_DEPTH, STORE_DEPTH, 1'b0);
    hold_go = ~hold_go;
    send_load(2, 3, 1'b0);
    send_load(3, 1, 1'b0);
    wait_idle();
    random_load(MODE_QUOTIENT);

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("covered %0d input transactions and %0d results in single and quotient modes",
             items_sent, results_seen);
    $display("including empty loads, store overflow, cancelling quotients and a long hold-off");
    if (mismatches == 0 && pending == 0) begin
      $display("polynomial_derivative_quotient_test: PASS");
    end else begin
      $display("polynomial_derivative_quotient_test: FAIL");
    end
    $finish;
  end
endmodule

// File: files.f
+incdir+hdl
hdl/pdq_pkg.sv
hdl/pdq_mem.sv
hdl/pdq_mac.sv
hdl/pdq_seq.sv
hdl/polynomial_derivative_quotient.sv
sim/pdq_tb_pkg.sv
sim/polynomial_derivative_quotient_checker.sv
sim/polynomial_derivative_quotient_test.sv
